// File: rtl/ntcc_pkg.sv
// shared types, constants and arithmetic helpers for the contact classifier
`default_nettype none
package ntcc_pkg;

  localparam int GW   = 64;
  localparam int DENW = 128;
  localparam int MAGW = 129;
  localparam int QW   = 31;
  localparam int RW   = MAGW + QW;
  localparam int NDIV = QW;
  localparam int DIV0 = 6;
  localparam int NST  = DIV0 + NDIV + 2;
  localparam int TOLW = 21;
  localparam logic [TOLW-1:0] TOL_RESET = 21'd1074;

  typedef enum logic [2:0] {
    CK_NONE      = 3'd0,
    CK_NODE_EDGE = 3'd1,
    CK_EDGE_NODE = 3'd2,
    CK_NODE_NODE = 3'd3,
    CK_NODE_TRI  = 3'd4,
    CK_TRI_NODE  = 3'd5
  } kind_t;

  typedef struct packed {
    logic          neg;
    logic [GW-1:0] mag;
  } sm64_t;

  function automatic logic signed [63:0] smul(logic signed [31:0] x, logic signed [31:0] y);
    return 64'(x) * 64'(y);
  endfunction

  function automatic logic signed [65:0] sum3(logic signed [63:0] x, logic signed [63:0] y,
                                              logic signed [63:0] z);
    return 66'(x) + 66'(y) + 66'(z);
  endfunction

  function automatic sm64_t sm_of(logic signed [65:0] s);
    sm64_t r;
    logic signed [65:0] n;
    n = -s;
    r.neg = s[65];
    r.mag = s[65] ? n[63:0] : s[63:0];
    return r;
  endfunction

  function automatic logic signed [129:0] sval(logic [127:0] p, logic neg);
    logic signed [129:0] x;
    x = $signed({2'b00, p});
    return neg ? -x : x;
  endfunction

endpackage
`default_nettype wire

// File: rtl/ntcc_if.sv
// request, result and configuration channel interfaces
`default_nettype none
interface ntcc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] edge_a_x;
  logic signed [31:0] edge_a_y;
  logic signed [31:0] edge_a_z;
  logic signed [31:0] edge_b_x;
  logic signed [31:0] edge_b_y;
  logic signed [31:0] edge_b_z;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic               node_on_first_body;
  modport source (output valid, edge_a_x, edge_a_y, edge_a_z, edge_b_x, edge_b_y, edge_b_z,
                  point_x, point_y, point_z, node_on_first_body, input ready);
  modport sink (input valid, edge_a_x, edge_a_y, edge_a_z, edge_b_x, edge_b_y, edge_b_z,
                point_x, point_y, point_z, node_on_first_body, output ready);
endinterface

interface ntcc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         contact_kind;
  logic [1:0]         local_index;
  logic signed [31:0] coord_a;
  logic signed [31:0] coord_b;
  modport source (output valid, contact_kind, local_index, coord_a, coord_b, input ready);
  modport sink (input valid, contact_kind, local_index, coord_a, coord_b, output ready);
endinterface

interface ntcc_cfg_if;
  logic        valid;
  logic        ready;
  logic [20:0] tolerance;
  modport source (output valid, tolerance, input ready);
  modport sink (input valid, tolerance, output ready);
endinterface
`default_nettype wire

// File: rtl/node_triangle_contact_classifier_unit.sv
// node-triangle contact classifier: gram system, cramer division and classification
// throughput: one request per cycle, stalls propagate stage by stage
// the 31 quotient bits come from a 31-stage restoring divider, one bit per stage
// reset clears all stage valid bits and loads tolerance with 1074
`default_nettype none
module node_triangle_contact_classifier_unit #(
  parameter int BARY_FRAC_BITS = 30
) (
  input  logic      clk,
  input  logic      rst_n,
  ntcc_in_if.sink   in_chan,
  ntcc_out_if.source out_chan,
  ntcc_cfg_if.sink  cfg_chan
);
  import ntcc_pkg::*;

  localparam int LAST = NST - 1;
  localparam int FIN  = DIV0 + NDIV;
  localparam logic signed [33:0] ONE = 34'sd1 <<< BARY_FRAC_BITS;

  logic [TOLW-1:0] tol_r;
  logic [NST-1:0]  v_r, en, first_r;

  logic signed [63:0] m_r [15];
  logic [GW-1:0]      g00_r, g11_r;
  sm64_t              g01_r, r0_r, r1_r;
  logic [63:0]        pp_r [6][4];
  logic [3:0]         sg2_r, sg3_r;
  logic [127:0]       prod_r [6];
  logic signed [128:0] det_r;
  logic signed [129:0] numa_r, numb_r;

  logic [RW-1:0]   rema_r [NDIV+1];
  logic [RW-1:0]   remb_r [NDIV+1];
  logic [QW-1:0]   qa_r [NDIV+1];
  logic [QW-1:0]   qb_r [NDIV+1];
  logic [DENW-1:0] den_r [NDIV+1];
  logic [NDIV:0]   nega_r, negb_r, sata_r, satb_r, dok_r;
  logic [RW-1:0]   tdiv [NDIV];
  logic [RW-1:0]   rema_nxt [NDIV];
  logic [RW-1:0]   remb_nxt [NDIV];
  logic [QW-1:0]   qa_nxt [NDIV];
  logic [QW-1:0]   qb_nxt [NDIV];

  logic signed [31:0] ca_r, cb_r, oa_r, ob_r;
  logic               fok_r;
  kind_t              kind_r, kind_nxt;
  logic [1:0]         lid_r, lid_nxt;

  // configuration
  assign cfg_chan.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_chan.valid) begin
      tol_r <= cfg_chan.tolerance;
    end
  end

  // stage enables
  always_comb begin
    en[LAST] = !v_r[LAST] || out_chan.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end
  assign in_chan.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_chan.valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) first_r[0] <= in_chan.node_on_first_body;
    for (int k = 1; k < NST; k++) begin
      if (en[k]) first_r[k] <= first_r[k-1];
    end
  end

  // stage 0: dot product terms
  always_ff @(posedge clk) begin
    if (en[0]) begin
      m_r[0]  <= smul(in_chan.edge_a_x, in_chan.edge_a_x);
      m_r[1]  <= smul(in_chan.edge_a_y, in_chan.edge_a_y);
      m_r[2]  <= smul(in_chan.edge_a_z, in_chan.edge_a_z);
      m_r[3]  <= smul(in_chan.edge_a_x, in_chan.edge_b_x);
      m_r[4]  <= smul(in_chan.edge_a_y, in_chan.edge_b_y);
      m_r[5]  <= smul(in_chan.edge_a_z, in_chan.edge_b_z);
      m_r[6]  <= smul(in_chan.edge_b_x, in_chan.edge_b_x);
      m_r[7]  <= smul(in_chan.edge_b_y, in_chan.edge_b_y);
      m_r[8]  <= smul(in_chan.edge_b_z, in_chan.edge_b_z);
      m_r[9]  <= smul(in_chan.edge_a_x, in_chan.point_x);
      m_r[10] <= smul(in_chan.edge_a_y, in_chan.point_y);
      m_r[11] <= smul(in_chan.edge_a_z, in_chan.point_z);
      m_r[12] <= smul(in_chan.edge_b_x, in_chan.point_x);
      m_r[13] <= smul(in_chan.edge_b_y, in_chan.point_y);
      m_r[14] <= smul(in_chan.edge_b_z, in_chan.point_z);
    end
  end

  // stage 1: gram entries in sign-magnitude
  logic signed [65:0] s00, s01, s11, sr0, sr1;
  assign s00 = sum3(m_r[0], m_r[1], m_r[2]);
  assign s01 = sum3(m_r[3], m_r[4], m_r[5]);
  assign s11 = sum3(m_r[6], m_r[7], m_r[8]);
  assign sr0 = sum3(m_r[9], m_r[10], m_r[11]);
  assign sr1 = sum3(m_r[12], m_r[13], m_r[14]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      g00_r <= s00[63:0];
      g11_r <= s11[63:0];
      g01_r <= sm_of(s01);
      r0_r  <= sm_of(sr0);
      r1_r  <= sm_of(sr1);
    end
  end

  // stage 2: 32x32 partial products of the six wide products
  logic [63:0] opa [6];
  logic [63:0] opb [6];
  always_comb begin
    opa[0] = g00_r;     opb[0] = g11_r;
    opa[1] = g01_r.mag; opb[1] = g01_r.mag;
    opa[2] = g11_r;     opb[2] = r0_r.mag;
    opa[3] = g01_r.mag; opb[3] = r1_r.mag;
    opa[4] = g00_r;     opb[4] = r1_r.mag;
    opa[5] = g01_r.mag; opb[5] = r0_r.mag;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 6; i++) begin
        pp_r[i][0] <= 64'(opa[i][31:0])  * 64'(opb[i][31:0]);
        pp_r[i][1] <= 64'(opa[i][31:0])  * 64'(opb[i][63:32]);
        pp_r[i][2] <= 64'(opa[i][63:32]) * 64'(opb[i][31:0]);
        pp_r[i][3] <= 64'(opa[i][63:32]) * 64'(opb[i][63:32]);
      end
      sg2_r <= {g01_r.neg ^ r0_r.neg, r1_r.neg, g01_r.neg ^ r1_r.neg, r0_r.neg};
    end
  end

  // stage 3: full products
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 6; i++) begin
        prod_r[i] <= {pp_r[i][3], pp_r[i][0]} + ({64'd0, pp_r[i][1]} << 32)
                     + ({64'd0, pp_r[i][2]} << 32);
      end
      sg3_r <= sg2_r;
    end
  end

  // stage 4: determinant and numerators
  always_ff @(posedge clk) begin
    if (en[4]) begin
      det_r  <= $signed({1'b0, prod_r[0]}) - $signed({1'b0, prod_r[1]});
      numa_r <= sval(prod_r[2], sg3_r[0]) - sval(prod_r[3], sg3_r[1]);
      numb_r <= sval(prod_r[4], sg3_r[2]) - sval(prod_r[5], sg3_r[3]);
    end
  end

  // stage 5: magnitudes, saturation and divider load
  logic signed [129:0] nna, nnb;
  logic [MAGW-1:0]     maga, magb;
  logic [RW-1:0]       ra0, rb0, dlim;
  assign nna  = -numa_r;
  assign nnb  = -numb_r;
  assign maga = numa_r[129] ? nna[MAGW-1:0] : numa_r[MAGW-1:0];
  assign magb = numb_r[129] ? nnb[MAGW-1:0] : numb_r[MAGW-1:0];
  assign ra0  = {{QW{1'b0}}, maga} << BARY_FRAC_BITS;
  assign rb0  = {{QW{1'b0}}, magb} << BARY_FRAC_BITS;
  assign dlim = {1'b0, det_r[DENW-1:0], {QW{1'b0}}};

  // restoring divider, one quotient bit per stage
  always_comb begin
    for (int j = 0; j < NDIV; j++) begin
      tdiv[j] = {{QW+1{1'b0}}, den_r[j]} << (QW - 1 - j);
      if (rema_r[j] >= tdiv[j]) begin
        rema_nxt[j] = rema_r[j] - tdiv[j];
        qa_nxt[j]   = qa_r[j] | (QW'(1) << (QW - 1 - j));
      end else begin
        rema_nxt[j] = rema_r[j];
        qa_nxt[j]   = qa_r[j];
      end
      if (remb_r[j] >= tdiv[j]) begin
        remb_nxt[j] = remb_r[j] - tdiv[j];
        qb_nxt[j]   = qb_r[j] | (QW'(1) << (QW - 1 - j));
      end else begin
        remb_nxt[j] = remb_r[j];
        qb_nxt[j]   = qb_r[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      rema_r[0] <= ra0;
      remb_r[0] <= rb0;
      qa_r[0]   <= '0;
      qb_r[0]   <= '0;
      den_r[0]  <= det_r[DENW-1:0];
      nega_r[0] <= numa_r[129];
      negb_r[0] <= numb_r[129];
      sata_r[0] <= ra0 >= dlim;
      satb_r[0] <= rb0 >= dlim;
      dok_r[0]  <= !det_r[128] && (det_r != '0);
    end
    for (int j = 0; j < NDIV; j++) begin
      if (en[DIV0+j]) begin
        rema_r[j+1] <= rema_nxt[j];
        remb_r[j+1] <= remb_nxt[j];
        qa_r[j+1]   <= qa_nxt[j];
        qb_r[j+1]   <= qb_nxt[j];
        den_r[j+1]  <= den_r[j];
        nega_r[j+1] <= nega_r[j];
        negb_r[j+1] <= negb_r[j];
        sata_r[j+1] <= sata_r[j];
        satb_r[j+1] <= satb_r[j];
        dok_r[j+1]  <= dok_r[j];
      end
    end
  end

  // signed, saturated coordinates
  logic signed [31:0] qa_s, qb_s, ca_nxt, cb_nxt;
  assign qa_s = $signed({1'b0, qa_r[NDIV]});
  assign qb_s = $signed({1'b0, qb_r[NDIV]});
  always_comb begin
    if (!dok_r[NDIV]) ca_nxt = '0;
    else if (sata_r[NDIV]) ca_nxt = nega_r[NDIV] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else ca_nxt = nega_r[NDIV] ? -qa_s : qa_s;
    if (!dok_r[NDIV]) cb_nxt = '0;
    else if (satb_r[NDIV]) cb_nxt = negb_r[NDIV] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else cb_nxt = negb_r[NDIV] ? -qb_s : qb_s;
  end

  always_ff @(posedge clk) begin
    if (en[FIN]) begin
      ca_r  <= ca_nxt;
      cb_r  <= cb_nxt;
      fok_r <= dok_r[NDIV];
    end
  end

  // classification
  logic signed [33:0] sa, sb, ssum, sdev, eps_s;
  logic               oor, za, zb, zs;
  assign sa    = 34'(ca_r);
  assign sb    = 34'(cb_r);
  assign ssum  = sa + sb;
  assign sdev  = ssum - ONE;
  assign eps_s = $signed({13'd0, tol_r});
  assign oor   = (sa > ONE + eps_s) || (sb > ONE + eps_s) || (sa < -eps_s) || (sb < -eps_s)
                 || (ssum > ONE + eps_s) || (ssum < -eps_s);
  assign za    = (sa <= eps_s) && (sa >= -eps_s);
  assign zb    = (sb <= eps_s) && (sb >= -eps_s);
  assign zs    = (sdev <= eps_s) && (sdev >= -eps_s);

  always_comb begin
    kind_nxt = CK_NONE;
    lid_nxt  = 2'd0;
    if (fok_r && !oor) begin
      unique case ({za, zb, zs})
        3'b000: kind_nxt = first_r[FIN] ? CK_NODE_TRI : CK_TRI_NODE;
        3'b100: begin
          kind_nxt = first_r[FIN] ? CK_NODE_EDGE : CK_EDGE_NODE;
          lid_nxt  = 2'd1;
        end
        3'b010: begin
          kind_nxt = first_r[FIN] ? CK_NODE_EDGE : CK_EDGE_NODE;
          lid_nxt  = 2'd2;
        end
        3'b001: kind_nxt = first_r[FIN] ? CK_NODE_EDGE : CK_EDGE_NODE;
        3'b110: begin
          kind_nxt = CK_NODE_NODE;
          lid_nxt  = 2'd2;
        end
        3'b101: begin
          kind_nxt = CK_NODE_NODE;
          lid_nxt  = 2'd1;
        end
        3'b011: kind_nxt = CK_NODE_NODE;
        3'b111: kind_nxt = CK_NODE_NODE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en[LAST]) begin
      kind_r <= kind_nxt;
      lid_r  <= lid_nxt;
      oa_r   <= ca_r;
      ob_r   <= cb_r;
    end
  end

  assign out_chan.valid        = v_r[LAST];
  assign out_chan.contact_kind = kind_r;
  assign out_chan.local_index  = lid_r;
  assign out_chan.coord_a      = oa_r;
  assign out_chan.coord_b      = ob_r;

`ifndef SYNTHESIS
  a_contact_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && (kind_r != CK_NONE) |->
      (34'(out_chan.coord_a) >= -eps_s) && (34'(out_chan.coord_b) >= -eps_s)
      && (34'(out_chan.coord_a) <= ONE + eps_s) && (34'(out_chan.coord_b) <= ONE + eps_s))
    else $error("contact reported with coordinates out of range");

  a_tri_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && ((kind_r == CK_NODE_TRI) || (kind_r == CK_TRI_NODE)) |->
      out_chan.local_index == 2'd0)
    else $error("triangle contact with nonzero local index");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_chan.valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[FIN] && !en[LAST] |=> v_r[FIN] && $stable(ca_r) && $stable(cb_r))
    else $error("stalled coordinate stage changed");
`endif

endmodule
`default_nettype wire

// File: test/tb_top.sv
// testbench for the node-triangle contact classifier: directed and random requests checked against a predictor
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ntcc_pkg::*;

  typedef struct {
    logic signed [31:0] e1 [3];
    logic signed [31:0] e2 [3];
    logic signed [31:0] pt [3];
    logic               first;
  } pair_t;

  typedef struct {
    kind_t              kind;
    logic [1:0]         lid;
    logic signed [31:0] ca;
    logic signed [31:0] cb;
  } contact_t;

  localparam longint ONE = 64'sd1 << 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ntcc_in_if  in_chan();
  ntcc_out_if out_chan();
  ntcc_cfg_if cfg_chan();

  node_triangle_contact_classifier_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  pair_t      pending_pairs [$];
  contact_t   contact_q [$];
  logic [20:0] cur_tol = TOL_RESET;
  bit         failed = 0;
  bit         no_idle = 0;
  int         send_gap = 0;
  int         recv_stall = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint bary_ratio(logic signed [255:0] num, logic signed [255:0] den);
    logic        neg;
    logic [255:0] mag, q;
    neg = num < 0;
    mag = neg ? $unsigned(-num) : $unsigned(num);
    mag = mag << 30;
    if (mag >= ($unsigned(den) << 31)) return neg ? -64'sd2147483648 : 64'sd2147483647;
    q = mag / $unsigned(den);
    return neg ? -longint'(q[31:0]) : longint'(q[31:0]);
  endfunction

  function automatic contact_t classify_contact(pair_t p, logic [20:0] tol);
    contact_t r;
    logic signed [255:0] a [3], b [3], c [3];
    logic signed [255:0] g00, g01, g11, r0, r1, det;
    longint ca, cb, sum, eps;
    int code;
    for (int i = 0; i < 3; i++) begin
      a[i] = p.e1[i];
      b[i] = p.e2[i];
      c[i] = p.pt[i];
    end
    g00 = a[0]*a[0] + a[1]*a[1] + a[2]*a[2];
    g01 = a[0]*b[0] + a[1]*b[1] + a[2]*b[2];
    g11 = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
    r0  = a[0]*c[0] + a[1]*c[1] + a[2]*c[2];
    r1  = b[0]*c[0] + b[1]*c[1] + b[2]*c[2];
    det = g00*g11 - g01*g01;
    r.kind = CK_NONE;
    r.lid = 2'd0;
    ca = 0;
    cb = 0;
    if (det > 0) begin
      ca = bary_ratio(g11*r0 - g01*r1, det);
      cb = bary_ratio(g00*r1 - g01*r0, det);
      eps = longint'(tol);
      sum = ca + cb;
      if (!(ca > ONE + eps || cb > ONE + eps || ca < -eps || cb < -eps ||
            sum > ONE + eps || sum < -eps)) begin
        code = 0;
        if (ca <= eps && ca >= -eps) begin
          code += 123;
          r.kind = p.first ? CK_NODE_EDGE : CK_EDGE_NODE;
          r.lid = 2'd1;
        end
        if (cb <= eps && cb >= -eps) begin
          code += 131;
          r.kind = p.first ? CK_NODE_EDGE : CK_EDGE_NODE;
          r.lid = 2'd2;
        end
        if (sum - ONE <= eps && ONE - sum <= eps) begin
          code += 112;
          r.kind = p.first ? CK_NODE_EDGE : CK_EDGE_NODE;
          r.lid = 2'd0;
        end
        if (code > 200) begin
          r.kind = CK_NODE_NODE;
          if (code == 254) r.lid = 2'd2;
          else if (code == 235) r.lid = 2'd1;
          else if (code == 243) r.lid = 2'd0;
        end
        if (code == 0) begin
          r.kind = p.first ? CK_NODE_TRI : CK_TRI_NODE;
          r.lid = 2'd0;
        end
      end
    end
    r.ca = ca[31:0];
    r.cb = cb[31:0];
    return r;
  endfunction

  function automatic pair_t build_pair(int ax, int ay, int az, int bx, int by, int bz,
                                       int px, int py, int pz, int first);
    pair_t p;
    p.e1[0] = ax; p.e1[1] = ay; p.e1[2] = az;
    p.e2[0] = bx; p.e2[1] = by; p.e2[2] = bz;
    p.pt[0] = px; p.pt[1] = py; p.pt[2] = pz;
    p.first = first[0];
    return p;
  endfunction

  function automatic pair_t noise_pair();
    return build_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom, $urandom_range(0, 1));
  endfunction

  // triangle with a node placed on a vertex, edge, interior or just outside
  function automatic pair_t shaped_pair();
    int e1 [3], e2 [3], pt [3];
    int s, t, mode, rng;
    rng = 1 << $urandom_range(4, 21);
    for (int i = 0; i < 3; i++) begin
      e1[i] = int'($urandom_range(0, 2*rng)) - rng;
      e2[i] = int'($urandom_range(0, 2*rng)) - rng;
    end
    mode = $urandom_range(0, 6);
    case (mode)
      0: begin s = 0; t = 0; end
      1: begin s = 256; t = 0; end
      2: begin s = 0; t = 256; end
      3: begin s = $urandom_range(0, 256); t = 0; end
      4: begin s = 0; t = $urandom_range(0, 256); end
      5: begin s = $urandom_range(0, 256); t = 256 - s; end
      default: begin s = $urandom_range(0, 320) - 32; t = $urandom_range(0, 320) - 32; end
    endcase
    for (int i = 0; i < 3; i++) begin
      pt[i] = (s * e1[i] + t * e2[i]) / 256;
      if ($urandom_range(0, 3) == 0) pt[i] += int'($urandom_range(0, 2)) - 1;
    end
    return build_pair(e1[0], e1[1], e1[2], e2[0], e2[1], e2[2], pt[0], pt[1], pt[2],
                      $urandom_range(0, 1));
  endfunction

  function automatic void queue_pair(pair_t p);
    pending_pairs = {pending_pairs, p};
  endfunction

  task automatic load_directed();
    int u = 65536;
    int mx = 32'h7fffffff;
    int mn = 32'h80000000;
    queue_pair(build_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    queue_pair(build_pair(u, 0, 0, 2*u, 0, 0, u, u, 0, 0));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, 0, 0, 0, 1));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, u, 0, 0, 0));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, 0, u, 0, 1));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, u/2, 0, 0, 1));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, 0, u/2, 0, 0));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, u/2, u/2, 0, 1));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, u/4, u/4, u, 0));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, u/4, u/4, 5, 1));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, -u, u/4, 0, 0));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, u, u, 0, 1));
    queue_pair(build_pair(1, 0, 0, 0, 1, 0, mx, mn, 0, 1));
    queue_pair(build_pair(1, 0, 0, 0, 1, 0, mn, mx, mx, 0));
    queue_pair(build_pair(mx, mn, mx, mn, mx, mx, mn, mn, mn, 1));
    queue_pair(build_pair(mn, mn, mn, mx, 0, mn, mx, mx, mx, 0));
    queue_pair(build_pair(mx, 0, 0, 0, mx, 0, mx, 0, 0, 1));
    queue_pair(build_pair(mn, 0, 0, 0, mn, 0, 0, 0, 0, 0));
    queue_pair(build_pair(-1, -1, -1, -1, 1, 0, -1, 0, 0, 1));
    queue_pair(build_pair(u, 0, 0, 0, u, 0, -1, u/3, 0, 0));
  endtask

  task automatic load_random(int n);
    repeat (n) begin
      if ($urandom_range(0, 3) == 0) queue_pair(noise_pair());
      else queue_pair(shaped_pair());
    end
  endtask

  task automatic drain();
    while (pending_pairs.size() != 0 || in_chan.valid || contact_q.size() != 0)
      @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_tolerance(logic [20:0] v);
    cfg_chan.valid <= 1'b1;
    cfg_chan.tolerance <= v;
    @(posedge clk);
    while (!cfg_chan.ready) @(posedge clk);
    cur_tol = v;
    cfg_chan.valid <= 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    pair_t p;
    logic  nv;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else if (!in_chan.valid || in_chan.ready) begin
      if (in_chan.valid) begin
        p.e1[0] = in_chan.edge_a_x; p.e1[1] = in_chan.edge_a_y; p.e1[2] = in_chan.edge_a_z;
        p.e2[0] = in_chan.edge_b_x; p.e2[1] = in_chan.edge_b_y; p.e2[2] = in_chan.edge_b_z;
        p.pt[0] = in_chan.point_x;  p.pt[1] = in_chan.point_y;  p.pt[2] = in_chan.point_z;
        p.first = in_chan.node_on_first_body;
        contact_q = {contact_q, classify_contact(p, cur_tol)};
      end
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (pending_pairs.size() != 0) begin
        p = pending_pairs.pop_front();
        in_chan.edge_a_x <= p.e1[0]; in_chan.edge_a_y <= p.e1[1]; in_chan.edge_a_z <= p.e1[2];
        in_chan.edge_b_x <= p.e2[0]; in_chan.edge_b_y <= p.e2[1]; in_chan.edge_b_z <= p.e2[2];
        in_chan.point_x <= p.pt[0];  in_chan.point_y <= p.pt[1];  in_chan.point_z <= p.pt[2];
        in_chan.node_on_first_body <= p.first;
        nv = 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 9);
      end
      in_chan.valid <= nv;
    end
  end

  // result monitor
  always @(posedge clk) begin
    contact_t e;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (contact_q.size() == 0) begin
          $display("%0t unexpected result kind %0d", $time, out_chan.contact_kind);
          failed = 1;
        end else begin
          e = contact_q.pop_front();
          if (out_chan.contact_kind !== e.kind) begin
            $display("%0t contact_kind exp %0d got %0d", $time, e.kind, out_chan.contact_kind);
            failed = 1;
          end
          if (out_chan.local_index !== e.lid) begin
            $display("%0t local_index exp %0d got %0d", $time, e.lid, out_chan.local_index);
            failed = 1;
          end
          if (out_chan.coord_a !== e.ca) begin
            $display("%0t coord_a exp %h got %h", $time, e.ca, out_chan.coord_a);
            failed = 1;
          end
          if (out_chan.coord_b !== e.cb) begin
            $display("%0t coord_b exp %h got %h", $time, e.cb, out_chan.coord_b);
            failed = 1;
          end
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
        if (!no_idle && $urandom_range(0, 7) == 0) recv_stall = $urandom_range(1, 9);
      end
    end
  end

  initial begin
    in_chan.valid = 1'b0;
    in_chan.edge_a_x = '0; in_chan.edge_a_y = '0; in_chan.edge_a_z = '0;
    in_chan.edge_b_x = '0; in_chan.edge_b_y = '0; in_chan.edge_b_z = '0;
    in_chan.point_x = '0;  in_chan.point_y = '0;  in_chan.point_z = '0;
    in_chan.node_on_first_body = 1'b0;
    out_chan.ready = 1'b0;
    cfg_chan.valid = 1'b0;
    cfg_chan.tolerance = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    load_directed();
    load_random(150);
    drain();
    write_tolerance(21'd0);
    load_directed();
    load_random(150);
    drain();
    write_tolerance(21'h1fffff);
    load_random(170);
    drain();
    write_tolerance(21'd1048576);
    load_random(190);
    while (pending_pairs.size() > 40) @(posedge clk);
    no_idle = 1;
    drain();
    if (failed || contact_q.size() != 0) begin
      $display("Test completed with failures");
    end else begin
      $display("Test completed successfully");
    end
    $finish;
  end
endmodule
`default_nettype wire
